// File: rtl/core/locality_aware_task_dispatcher_top_assert.svh
// assertion macros shared by the dispatcher rtl
`ifndef LOCALITY_AWARE_TASK_DISPATCHER_TOP_ASSERT_SVH
`define LOCALITY_AWARE_TASK_DISPATCHER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LATD_ASSERT_IMP(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LATD_ASSERT_NXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/latd_pkg.sv
// shared types and constants of the locality-aware task dispatcher
`timescale 1ns / 1ps
`default_nettype none

package latd_pkg;

  // table size default
  localparam int LATD_TABLE_DEPTH = 64;

  // field widths
  localparam int CHUNK_W  = 16;
  localparam int RAW_W    = 16;
  localparam int HOME_W   = 8;
  localparam int WC_W     = 8;
  localparam int STATUS_W = 3;

  // action codes of the input request
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_REQ  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_LOCAL  = 3'd0,
    STS_REMOTE = 3'd1,
    STS_EMPTY  = 3'd2,
    STS_LOADED = 3'd3,
    STS_FULL   = 3'd4
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/latd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module latd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/locality_aware_task_dispatcher_top.sv
// Locality-aware task dispatcher: table of pending tasks with local-first pickup.
// Input channel: an item is taken at a rising edge with start high and busy low.
//   in_action low loads in_chunk_id with home (in_raw_locality mod worker_count)+1;
//   in_action high asks for a task on behalf of worker in_requester.
// Result channel: out_valid is high for one cycle with out_status, out_task_chunk
//   and out_task_home; the receiver cannot hold results off, and none is queued.
// Configuration: cfg_worker_count is written when cfg_valid and cfg_ready are
//   high; cfg_ready is high while the block is idle. A count of zero acts as one.
// Steps from the accepting edge to the result:
//   load on a full table, request on an empty table: result registered in the next cycle
//   load: runs the 16-step bit-serial remainder loop, then writes the table entry
//   request: a scan over the table ram read port, one entry per cycle, that stops at
//   the first live entry homed on the requester (local dispatch) or else at the
//   write position (non-local dispatch of the oldest live entry); busy stays high
//   for the whole item.
// Reset (synchronous, rst_n low) empties the table, sets the write position to
// zero and worker_count to one. Table memory contents are not cleared: only
// entries with a set valid bit are ever returned.
`timescale 1ns / 1ps
`default_nettype none

`include "locality_aware_task_dispatcher_top_assert.svh"

module locality_aware_task_dispatcher_top #(
  parameter int TABLE_DEPTH = latd_pkg::LATD_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [latd_pkg::CHUNK_W-1:0]   in_chunk_id,
  input  logic [latd_pkg::RAW_W-1:0]     in_raw_locality,
  input  logic [latd_pkg::HOME_W-1:0]    in_requester,
  output logic                           out_valid,
  output logic [latd_pkg::STATUS_W-1:0]  out_status,
  output logic [latd_pkg::CHUNK_W-1:0]   out_task_chunk,
  output logic [latd_pkg::HOME_W-1:0]    out_task_home,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [latd_pkg::WC_W-1:0]      cfg_worker_count
);

  import latd_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int PW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = CHUNK_W + HOME_W;
  localparam int CW = $clog2(RAW_W);
  localparam int SW = HOME_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MOD  = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [WC_W-1:0]     wc_r, wc_nxt;
  logic [PW-1:0]       wp_r, wp_nxt;
  logic [PW-1:0]       live_r, live_nxt;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [CHUNK_W-1:0]  chunk_r, chunk_nxt;
  logic [HOME_W-1:0]   who_r, who_nxt;
  logic [RAW_W-1:0]    dvd_r, dvd_nxt;
  logic [HOME_W-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]       step_r, step_nxt;
  logic [IW-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                cmp_live_r, cmp_live_nxt;
  logic                old_found_r, old_found_nxt;
  logic [IW-1:0]       old_idx_r, old_idx_nxt;
  logic [CHUNK_W-1:0]  old_chunk_r, old_chunk_nxt;
  logic [HOME_W-1:0]   old_home_r, old_home_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             status_r, status_nxt;
  logic [CHUNK_W-1:0]  res_chunk_r, res_chunk_nxt;
  logic [HOME_W-1:0]   res_home_r, res_home_nxt;

  // table ram signals
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  logic [CHUNK_W-1:0]  rd_chunk;
  logic [HOME_W-1:0]   rd_home;

  // shared subtract/compare unit
  logic [SW-1:0]       su_a, su_b;
  logic [SW:0]         su_diff;
  logic                su_ge, su_eq;

  logic [WC_W-1:0]     wc_eff;
  logic [HOME_W-1:0]   rem_new;
  logic                ent_live, is_last;

  latd_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  assign rd_chunk = ram_rdata[EW-1:HOME_W];
  assign rd_home  = ram_rdata[HOME_W-1:0];

  // zero worker count behaves as one
  assign wc_eff = (wc_r == '0) ? WC_W'(1) : wc_r;

  // operand select: remainder step while loading, home match while scanning
  always_comb begin
    if (state_r == ST_SCAN) begin
      su_a = {1'b0, rd_home};
      su_b = {1'b0, who_r};
    end else begin
      su_a = {rem_r, dvd_r[RAW_W-1]};
      su_b = {1'b0, wc_eff};
    end
  end

  assign su_diff = {1'b0, su_a} - {1'b0, su_b};
  assign su_ge   = ~su_diff[SW];
  assign su_eq   = (su_diff == '0);

  // restoring remainder step result
  assign rem_new = su_ge ? su_diff[HOME_W-1:0] : su_a[HOME_W-1:0];

  // scan pipeline: entry under compare lags the read address by one register
  assign ent_live = cmp_live_r & valid_r[cmp_idx_r];
  assign is_last  = (PW'(cmp_idx_r) == (wp_r - PW'(1)));

  // table write on the final remainder step
  assign ram_we    = (state_r == ST_MOD) && (step_r == CW'(RAW_W - 1));
  assign ram_waddr = wp_r[IW-1:0];
  assign ram_wdata = {chunk_r, rem_new + HOME_W'(1)};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wc_nxt        = wc_r;
    wp_nxt        = wp_r;
    live_nxt      = live_r;
    valid_nxt     = valid_r;
    chunk_nxt     = chunk_r;
    who_nxt       = who_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_live_nxt  = cmp_live_r;
    old_found_nxt = old_found_r;
    old_idx_nxt   = old_idx_r;
    old_chunk_nxt = old_chunk_r;
    old_home_nxt  = old_home_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    res_chunk_nxt = res_chunk_r;
    res_home_nxt  = res_home_r;

    if (cfg_valid && cfg_ready) begin
      wc_nxt = cfg_worker_count;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_action == ACT_LOAD) begin
            if (wp_r == PW'(TABLE_DEPTH)) begin
              out_valid_nxt = 1'b1;
              status_nxt    = STS_FULL;
              res_chunk_nxt = '0;
              res_home_nxt  = '0;
            end else begin
              chunk_nxt = in_chunk_id;
              dvd_nxt   = in_raw_locality;
              rem_nxt   = '0;
              step_nxt  = '0;
              state_nxt = ST_MOD;
            end
          end else begin
            if (live_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = STS_EMPTY;
              res_chunk_nxt = '0;
              res_home_nxt  = '0;
            end else begin
              who_nxt       = in_requester;
              scan_idx_nxt  = '0;
              cmp_live_nxt  = 1'b0;
              old_found_nxt = 1'b0;
              state_nxt     = ST_SCAN;
            end
          end
        end
      end

      ST_MOD: begin
        // one quotient bit per cycle, msb first
        rem_nxt  = rem_new;
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + CW'(1);
        if (ram_we) begin
          valid_nxt[wp_r[IW-1:0]] = 1'b1;
          wp_nxt        = wp_r + PW'(1);
          live_nxt      = live_r + PW'(1);
          out_valid_nxt = 1'b1;
          status_nxt    = STS_LOADED;
          res_chunk_nxt = '0;
          res_home_nxt  = '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + IW'(1);
        cmp_idx_nxt  = scan_idx_r;
        cmp_live_nxt = 1'b1;
        // remember the oldest live entry
        if (ent_live && !old_found_r) begin
          old_found_nxt = 1'b1;
          old_idx_nxt   = cmp_idx_r;
          old_chunk_nxt = rd_chunk;
          old_home_nxt  = rd_home;
        end
        if (cmp_live_r && (ent_live && su_eq || is_last)) begin
          out_valid_nxt = 1'b1;
          live_nxt      = live_r - PW'(1);
          if (live_r == PW'(1)) begin
            wp_nxt = '0;
          end
          state_nxt = ST_IDLE;
          if (ent_live && su_eq) begin
            // local hit
            valid_nxt[cmp_idx_r] = 1'b0;
            status_nxt    = STS_LOCAL;
            res_chunk_nxt = rd_chunk;
            res_home_nxt  = rd_home;
          end else if (old_found_r) begin
            valid_nxt[old_idx_r] = 1'b0;
            status_nxt    = STS_REMOTE;
            res_chunk_nxt = old_chunk_r;
            res_home_nxt  = old_home_r;
          end else begin
            // last entry is also the oldest live one
            valid_nxt[cmp_idx_r] = 1'b0;
            status_nxt    = STS_REMOTE;
            res_chunk_nxt = rd_chunk;
            res_home_nxt  = rd_home;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wc_r        <= WC_W'(1);
      wp_r        <= '0;
      live_r      <= '0;
      valid_r     <= '0;
      cmp_live_r  <= 1'b0;
      old_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wc_r        <= wc_nxt;
      wp_r        <= wp_nxt;
      live_r      <= live_nxt;
      valid_r     <= valid_nxt;
      cmp_live_r  <= cmp_live_nxt;
      old_found_r <= old_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    chunk_r     <= chunk_nxt;
    who_r       <= who_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    old_idx_r   <= old_idx_nxt;
    old_chunk_r <= old_chunk_nxt;
    old_home_r  <= old_home_nxt;
    status_r    <= status_nxt;
    res_chunk_r <= res_chunk_nxt;
    res_home_r  <= res_home_nxt;
  end

  // ports
  assign busy           = (state_r != ST_IDLE);
  assign cfg_ready      = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_task_chunk = res_chunk_r;
  assign out_task_home  = res_home_r;

  // checks
  `LATD_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, state_r == ST_IDLE,
                   "result strobe while item still in progress")
  `LATD_ASSERT_IMP(a_live_le_wp, clk, rst_n, 1'b1, live_r <= wp_r,
                   "live task count exceeds write position")
  `LATD_ASSERT_IMP(a_scan_nonempty, clk, rst_n, state_r == ST_SCAN, live_r != '0,
                   "scan running on an empty table")
  `LATD_ASSERT_NXT(a_empty_reply, clk, rst_n,
                   start && !busy && in_action == ACT_REQ && live_r == '0,
                   out_valid && out_status == STS_EMPTY,
                   "request on empty table not answered next cycle")
  `LATD_ASSERT_IMP(a_dispatch_home, clk, rst_n,
                   out_valid && (out_status == STS_LOCAL || out_status == STS_REMOTE),
                   out_task_home != '0,
                   "dispatched task carries a zero home")

endmodule

`default_nettype wire

// File: tb/locality_aware_task_dispatcher_top_test.sv
// testbench of the locality-aware task dispatcher: scoreboard class, request driver, checks
`timescale 1ns / 1ps

module locality_aware_task_dispatcher_top_test;
  import latd_pkg::*;

  localparam int DEPTH = LATD_TABLE_DEPTH;
  localparam int REQUEST_GOAL = 1000;
  localparam int DRAIN_CYCLES = DEPTH + 8;

  // one predicted outcome of a request
  typedef struct {
    status_t           status;
    logic [CHUNK_W-1:0] chunk;
    logic [HOME_W-1:0]  home;
  } outcome_t;

  // predictor of the task table plus the queue of outcomes still to arrive
  class dispatch_scoreboard;
    logic [CHUNK_W-1:0] slot_chunk [DEPTH];
    logic [HOME_W-1:0]  slot_home [DEPTH];
    bit                 slot_used [DEPTH];
    int unsigned        fill_pos;
    int unsigned        live;
    logic [WC_W-1:0]    workers;
    outcome_t           awaited[$];
    int unsigned        errors;
    int unsigned        accepted;
    int unsigned        tally [5];

    function new();
      fill_pos = 0;
      live = 0;
      workers = 8'd1;
      errors = 0;
      accepted = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function void set_workers(logic [WC_W-1:0] v);
      workers = v;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // work out the outcome of one accepted request and update the table
    function void note_request(logic action, logic [CHUNK_W-1:0] chunk,
                               logic [RAW_W-1:0] raw, logic [HOME_W-1:0] who);
      outcome_t    o;
      int unsigned divisor;
      int          hit;
      int          first;
      o.status = STS_LOADED;
      o.chunk = '0;
      o.home = '0;
      if (action == ACT_LOAD) begin
        divisor = (workers == 0) ? 1 : workers;
        if (fill_pos >= DEPTH) begin
          o.status = STS_FULL;
        end else begin
          slot_chunk[fill_pos] = chunk;
          slot_home[fill_pos] = HOME_W'(raw % divisor + 1);
          slot_used[fill_pos] = 1'b1;
          fill_pos++;
          live++;
        end
      end else begin
        // oldest task homed on the requester, else oldest overall
        hit = -1;
        first = -1;
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i]) begin
            if (first < 0) first = i;
            if (slot_home[i] == who) begin
              hit = i;
              break;
            end
          end
        end
        if (first < 0) begin
          o.status = STS_EMPTY;
        end else begin
          if (hit >= 0) begin
            o.status = STS_LOCAL;
          end else begin
            hit = first;
            o.status = STS_REMOTE;
          end
          o.chunk = slot_chunk[hit];
          o.home = slot_home[hit];
          slot_used[hit] = 1'b0;
          live--;
          if (live == 0) fill_pos = 0;
        end
      end
      tally[o.status]++;
      accepted++;
      awaited.insert(awaited.size(), o);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // compare one result against the oldest outcome waiting
    task check_result(logic [STATUS_W-1:0] status, logic [CHUNK_W-1:0] chunk,
                      logic [HOME_W-1:0] home);
      outcome_t o;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d chunk %h home %0d",
                                  status, chunk, home));
        return;
      end
      o = awaited.pop_front();
      if (status !== o.status)
        report_mismatch($sformatf("status %0d, want %0d", status, o.status));
      if (chunk !== o.chunk)
        report_mismatch($sformatf("task_chunk %h, want %h", chunk, o.chunk));
      if (home !== o.home)
        report_mismatch($sformatf("task_home %0d, want %0d", home, o.home));
    endtask

    task close_out();
      if (awaited.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", awaited.size()));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_action;
  logic [CHUNK_W-1:0]  in_chunk_id;
  logic [RAW_W-1:0]    in_raw_locality;
  logic [HOME_W-1:0]   in_requester;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CHUNK_W-1:0]  out_task_chunk;
  logic [HOME_W-1:0]   out_task_home;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WC_W-1:0]     cfg_worker_count;

  dispatch_scoreboard sb;
  int unsigned        burst_left;
  bit                 gaps_on;
  int unsigned        cfg_writes;

  locality_aware_task_dispatcher_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_chunk_id     (in_chunk_id),
    .in_raw_locality (in_raw_locality),
    .in_requester    (in_requester),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_task_chunk  (out_task_chunk),
    .out_task_home   (out_task_home),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_worker_count(cfg_worker_count)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // watchdog
  initial begin
    #20_000_000;
    $display("timeout: dispatcher stopped making progress");
    $display("Simulation FAILED");
    $finish;
  end

  // monitor: note accepted requests, check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_request(in_action, in_chunk_id, in_raw_locality, in_requester);
      if (out_valid)
        sb.check_result(out_status, out_task_chunk, out_task_home);
    end
  end

  // gaps between bursts of requests
  task automatic pace_sender();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // drive one request and wait until it is taken
  task automatic issue(input logic action, input logic [CHUNK_W-1:0] chunk,
                       input logic [RAW_W-1:0] raw, input logic [HOME_W-1:0] who);
    start <= 1'b1;
    in_action <= action;
    in_chunk_id <= chunk;
    in_raw_locality <= raw;
    in_requester <= who;
    @(posedge clk);
    while (busy) @(posedge clk);
    pace_sender();
  endtask

  task automatic issue_load(input logic [CHUNK_W-1:0] chunk, input logic [RAW_W-1:0] raw);
    issue(ACT_LOAD, chunk, raw, HOME_W'($urandom));
  endtask

  task automatic issue_pickup(input logic [HOME_W-1:0] who);
    issue(ACT_REQ, CHUNK_W'($urandom), RAW_W'($urandom), who);
  endtask

  // let every outstanding result come back before touching the register
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_workers(input logic [WC_W-1:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_worker_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_workers(v);
    cfg_writes++;
  endtask

  // mostly workers in range, sometimes zero, one past the count, or anything
  function automatic logic [HOME_W-1:0] pick_requester();
    int unsigned eff;
    int unsigned r;
    eff = (sb.workers == 0) ? 1 : sb.workers;
    r = $urandom_range(0, 9);
    if (r < 7) return HOME_W'($urandom_range(1, eff));
    if (r == 7) return '0;
    if (r == 8) return HOME_W'(eff + 1);
    return HOME_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [WC_W-1:0] pick_workers();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'd1;
      2: return 8'd255;
      5: return WC_W'($urandom_range(1, 255));
      default: return WC_W'($urandom_range(2, 8));
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned load_pct;
    int unsigned round_len;
    sb = new();
    burst_left = 1;
    gaps_on = 1'b0;
    cfg_writes = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_LOAD;
    in_chunk_id <= '0;
    in_raw_locality <= '0;
    in_requester <= '0;
    cfg_valid <= 1'b0;
    cfg_worker_count <= 8'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, field extremes, local and non-local pickup
    issue_pickup(8'd1);
    issue_load(16'h0000, 16'h0000);
    issue_load(16'hffff, 16'hffff);
    issue_pickup(8'd0);
    issue_pickup(8'd1);
    issue_pickup(8'd255);

    // zero worker count acts as one
    write_workers(8'd0);
    issue_load(16'h1234, 16'hffff);
    issue_load(16'h00ff, 16'h7f3c);
    issue_pickup(8'd2);
    issue_pickup(8'd1);

    // widest worker count, newer task picked over older ones
    write_workers(8'd255);
    issue_load(16'haaaa, 16'hffff);
    issue_load(16'h5555, 16'd254);
    issue_load(16'hc3c3, 16'd253);
    issue_pickup(8'd255);
    issue_pickup(8'd0);
    issue_pickup(8'd254);
    issue_pickup(8'd254);

    // requester one past the count
    write_workers(8'd3);
    issue_load(16'h0f0f, 16'd5);
    issue_load(16'hf0f0, 16'd4);
    issue_pickup(8'd4);
    issue_pickup(8'd2);
    issue_pickup(8'd2);

    // random rounds; load-heavy rounds fill the table, request-heavy ones drain it
    while (sb.accepted < REQUEST_GOAL) begin
      write_workers(pick_workers());
      case ($urandom_range(0, 3))
        0: load_pct = 20;
        1: load_pct = 50;
        2: load_pct = 70;
        default: load_pct = 90;
      endcase
      round_len = $urandom_range(30, 90);
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 12);
      repeat (round_len) begin
        if ($urandom_range(1, 100) <= load_pct)
          issue_load(CHUNK_W'($urandom), RAW_W'($urandom));
        else
          issue_pickup(pick_requester());
      end
    end

    // drain and finish
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    $display("covered %0d requests over %0d worker-count writes", sb.accepted, cfg_writes);
    $display("outcomes: %0d local, %0d non-local, %0d empty, %0d loaded, %0d full",
             sb.tally[STS_LOCAL], sb.tally[STS_REMOTE], sb.tally[STS_EMPTY],
             sb.tally[STS_LOADED], sb.tally[STS_FULL]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/latd_pkg.sv
rtl/core/latd_ram.sv
rtl/core/locality_aware_task_dispatcher_top.sv
tb/locality_aware_task_dispatcher_top_test.sv
